FILE: rtl/core/csa2_pkg.sv
// shared constants, types and request codes for the csa#2 channel select unit
// no dependencies; used by csa2_ctrl, csa2_dp and the top level
`timescale 1ns / 1ps

package csa2_pkg;

    // number of data channels scanned and used as the plain modulus (37 to 40)
    localparam int NUM_CHANNELS = 37;

    localparam int MAP_W     = 37;
    localparam int MAP_EXT_W = MAP_W + NUM_CHANNELS;
    localparam int CHAN_W    = 6;
    localparam int SCAN_W    = $clog2(NUM_CHANNELS);
    localparam int CNT_W     = 6;
    localparam int ID_W      = 16;
    localparam int PRN_W     = 16;
    localparam int TYPE_W    = 2;
    localparam int DVD_W     = 16;
    localparam int DCNT_W    = $clog2(DVD_W);

    // reciprocal for the event modulus; exact for 16-bit dividends and moduli from 33 to 64
    localparam int          RECIP_SH = 22;
    localparam int          QUOT_W   = 11;
    localparam logic [16:0] RECIP_M  =
        17'(((1 << RECIP_SH) + NUM_CHANNELS - 1) / NUM_CHANNELS);

    // request kinds
    localparam logic [TYPE_W-1:0] REQ_EVENT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FIRST = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_NEXT  = 2'd2;

    // register indexes on the configuration port
    localparam int ADDR_W = 5;
    localparam logic [1:0] REG_MAP   = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_ID    = 2'd2;

    typedef struct packed {
        logic load;
        logic round;
        logic prep;
        logic div_step;
        logic setup;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_next;
        logic div_last;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/core/csa2_ctrl.sv
// sequencer for the csa#2 channel select unit
// depends on csa2_pkg; drives the command struct of csa2_dp
`timescale 1ns / 1ps

module csa2_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  csa2_pkg::t_dp_stat i_stat,
    output csa2_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SETUP = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_rnd, n_rnd;
    logic [1:0] rnd_last;

    // next subevent needs one round, events three
    assign rnd_last = i_stat.is_next ? 2'd0 : 2'd2;

    always_comb begin
        n_state    = r_state;
        n_rnd      = r_rnd;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_rnd      = 2'd0;
                    n_state    = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_rnd == rnd_last) begin
                    n_state = S_PREP;
                end else begin
                    n_rnd = r_rnd + 2'd1;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
        end
    end

endmodule

FILE: rtl/core/csa2_dp.sv
// datapath for the csa#2 channel select unit: prn rounds, modulus units,
// used-channel scan, kept iso state and output register; depends on csa2_pkg
`timescale 1ns / 1ps

module csa2_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  csa2_pkg::t_dp_cmd               i_cmd,
    output csa2_pkg::t_dp_stat              o_stat,
    input  logic [csa2_pkg::TYPE_W-1:0]     i_req_type,
    input  logic [15:0]                    i_evt_count,
    input  logic [csa2_pkg::MAP_W-1:0]      i_channel_map,
    input  logic [csa2_pkg::CNT_W-1:0]      i_used_count,
    input  logic [csa2_pkg::ID_W-1:0]       i_chan_id,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output logic [csa2_pkg::CHAN_W-1:0]     o_channel,
    output logic [csa2_pkg::CHAN_W-1:0]     o_used_index
);

    // bit reversal inside each byte
    function automatic logic [15:0] rev_bytes(input logic [15:0] x);
        logic [15:0] p;
        for (int j = 0; j < 8; j++) begin
            p[j]     = x[7-j];
            p[8+j]   = x[15-j];
        end
        return p;
    endfunction

    // one prn round: reverse, times 17, plus identifier
    function automatic logic [15:0] prn_round(input logic [15:0] x, input logic [15:0] id);
        logic [15:0] p;
        p = rev_bytes(x);
        return p + {p[11:0], 4'b0000} + id;
    endfunction

    // subevent spacing from the used-channel count
    function automatic logic [3:0] spacing(input logic [5:0] n);
        logic [5:0] x;
        logic [5:0] y;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] m;
        x = (n > 6'd5) ? n - 6'd5 : 6'd0;
        y = (n > 6'd10) ? (n - 6'd10) >> 1 : 6'd0;
        a = (x < 6'd3) ? x[3:0] : 4'd3;
        b = (y < 6'd11) ? y[3:0] : 4'd11;
        m = (a > b) ? a : b;
        return (m > 4'd1) ? m : 4'd1;
    endfunction

    // working registers
    logic [csa2_pkg::TYPE_W-1:0] r_type;
    logic [csa2_pkg::PRN_W-1:0]  r_x;
    logic [csa2_pkg::CHAN_W-1:0] r_nfresh;
    logic [csa2_pkg::CHAN_W-1:0] r_ch0;
    logic                        r_fresh;
    logic [csa2_pkg::CHAN_W-1:0] r_target;
    // divider
    logic [csa2_pkg::DVD_W-1:0]  r_dvd;
    logic [csa2_pkg::CHAN_W-1:0] r_rem;
    logic [csa2_pkg::CHAN_W-1:0] r_dvs;
    logic                        r_dvs_zero;
    logic [csa2_pkg::DCNT_W-1:0] r_dcnt;
    logic [csa2_pkg::QUOT_W-1:0] r_quot;
    // scan
    logic [csa2_pkg::SCAN_W-1:0] r_scan_i;
    logic [csa2_pkg::CHAN_W-1:0] r_scan_cnt;
    logic                        r_found;
    logic [csa2_pkg::SCAN_W-1:0] r_found_ch;
    logic [csa2_pkg::CHAN_W-1:0] r_below;
    // kept iso state
    logic [csa2_pkg::PRN_W-1:0]  r_prn_lu;
    logic [csa2_pkg::CHAN_W-1:0] r_stored_remap;
    // output register
    logic                        r_m_valid;
    logic [csa2_pkg::CHAN_W-1:0] r_m_ch;
    logic [csa2_pkg::CHAN_W-1:0] r_m_remap;

    logic                          is_next;
    logic                          is_first;
    logic [csa2_pkg::MAP_EXT_W-1:0] map_ext;
    logic [csa2_pkg::NUM_CHANNELS-1:0] used_vec;
    logic [csa2_pkg::PRN_W-1:0]    e_val;
    logic [21:0]                   prod_ne;
    logic [3:0]                    d_val;
    logic [6:0]                    n_plus;
    logic [6:0]                    d_twice;
    logic [6:0]                    x_val;
    logic [22:0]                   prod_sx;
    logic [7:0]                    sum_val;
    logic [32:0]                   prod_q;
    logic [15:0]                   quot_mul;
    logic [15:0]                   ev_rem;
    logic [6:0]                    div_t;
    logic [csa2_pkg::CHAN_W-1:0]   div_res;
    logic                          scan_used;
    logic [csa2_pkg::CHAN_W-1:0]   hit_ch;
    logic [csa2_pkg::CHAN_W-1:0]   fin_ch;
    logic [csa2_pkg::CHAN_W-1:0]   fin_idx;

    assign is_next  = (r_type == csa2_pkg::REQ_NEXT);
    assign is_first = (r_type == csa2_pkg::REQ_FIRST);

    // channels at or above the map width never count as used
    assign map_ext  = {{csa2_pkg::NUM_CHANNELS{1'b0}}, i_channel_map};
    assign used_vec = map_ext[csa2_pkg::NUM_CHANNELS-1:0];

    // prep arithmetic, one multiply each way
    assign e_val   = r_x ^ i_chan_id;
    assign prod_ne = i_used_count * e_val;
    assign d_val   = spacing(i_used_count);
    assign n_plus  = {1'b0, i_used_count} + 7'd1;
    assign d_twice = {2'b00, d_val, 1'b0};
    assign x_val   = (n_plus > d_twice) ? n_plus - d_twice : 7'd0;
    assign prod_sx = e_val * x_val;
    assign sum_val = {1'b0, prod_sx[22:16]} + {4'b0000, d_val} + {2'b00, r_stored_remap};

    // event modulus: quotient by reciprocal in prep, remainder in the divide step that follows
    assign prod_q   = e_val * csa2_pkg::RECIP_M;
    assign quot_mul = 16'(r_quot * csa2_pkg::NUM_CHANNELS);
    assign ev_rem   = r_dvd - quot_mul;

    // restoring divider step, subevent index modulo the count
    assign div_t   = {r_rem, r_dvd[csa2_pkg::DVD_W-1]};
    assign div_res = r_dvs_zero ? '0 : r_rem;

    assign scan_used = used_vec[r_scan_i];
    assign hit_ch    = r_found ? csa2_pkg::CHAN_W'(r_found_ch) : '0;

    always_comb begin
        if (is_next || r_fresh) begin
            fin_ch  = hit_ch;
            fin_idx = r_target;
        end else begin
            fin_ch  = r_ch0;
            fin_idx = r_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_x    <= (i_req_type == csa2_pkg::REQ_NEXT) ? r_prn_lu
                                                         : (i_evt_count ^ i_chan_id);
        end
        if (i_cmd.round) begin
            r_x <= prn_round(r_x, i_chan_id);
        end
        if (i_cmd.prep) begin
            r_rem    <= '0;
            r_nfresh <= prod_ne[21:16];
            if (is_next) begin
                r_dcnt     <= csa2_pkg::DCNT_W'(csa2_pkg::DVD_W - 1);
                r_dvd      <= {8'h00, sum_val};
                r_dvs      <= i_used_count;
                r_dvs_zero <= (i_used_count == '0);
            end else begin
                // events need a single remainder step
                r_dcnt     <= '0;
                r_dvd      <= e_val;
                r_quot     <= prod_q[csa2_pkg::RECIP_SH +: csa2_pkg::QUOT_W];
                r_dvs_zero <= 1'b0;
            end
        end
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (is_next) begin
                r_dvd <= {r_dvd[csa2_pkg::DVD_W-2:0], 1'b0};
                if (div_t >= {1'b0, r_dvs}) begin
                    r_rem <= csa2_pkg::CHAN_W'(div_t - {1'b0, r_dvs});
                end else begin
                    r_rem <= div_t[csa2_pkg::CHAN_W-1:0];
                end
            end else begin
                r_rem <= ev_rem[csa2_pkg::CHAN_W-1:0];
            end
        end
        if (i_cmd.setup) begin
            r_ch0      <= div_res;
            r_fresh    <= is_next || !used_vec[csa2_pkg::SCAN_W'(div_res)];
            r_target   <= is_next ? div_res : r_nfresh;
            r_scan_i   <= '0;
            r_scan_cnt <= '0;
            r_found    <= 1'b0;
            r_found_ch <= '0;
            r_below    <= '0;
        end
        if (i_cmd.scan_step) begin
            r_scan_i <= r_scan_i + 1'b1;
            if (csa2_pkg::CHAN_W'(r_scan_i) == r_ch0) begin
                r_below <= r_scan_cnt;
            end
            if (scan_used) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
                if (!r_found && r_scan_cnt == r_target) begin
                    r_found    <= 1'b1;
                    r_found_ch <= r_scan_i;
                end
            end
        end
        if (i_cmd.commit) begin
            r_m_ch    <= fin_ch;
            r_m_remap <= (is_next || is_first) ? fin_idx : '0;
        end
    end

    // kept iso state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prn_lu       <= '0;
            r_stored_remap <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cmd.commit && (is_next || is_first)) begin
                r_prn_lu       <= r_x;
                r_stored_remap <= fin_idx;
            end
            if (i_cmd.commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_next   = (r_type == csa2_pkg::REQ_NEXT);
    assign o_stat.div_last  = (r_dcnt == '0);
    assign o_stat.scan_last = (r_scan_i == csa2_pkg::SCAN_W'(csa2_pkg::NUM_CHANNELS - 1));
    assign o_stat.out_free  = !r_m_valid || i_m_ready;

    assign o_m_valid    = r_m_valid;
    assign o_channel    = r_m_ch;
    assign o_used_index = r_m_remap;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_m_valid || i_m_ready))
        else $error("result written over a beat not yet taken");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_ch < csa2_pkg::NUM_CHANNELS))
        else $error("selected channel out of range");

    a_remap_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && is_next && !r_dvs_zero) |-> (r_target < r_dvs))
        else $error("subevent index not reduced below the count");

endmodule

FILE: rtl/core/ble_csa2_channel_select_unit.sv
// top level of the csa#2 channel select unit: apb registers, stream ports,
// sequencer csa2_ctrl and datapath csa2_dp; depends on csa2_pkg
// requests are taken one at a time and only while the sequencer is idle; the time per
//   request is set by the one-channel-a-cycle map scan and, on a next subevent, the
//   16-step divider, and a result is handed over only once the output is free
// the input is taken again while a finished result still waits on the output
// reset: synchronous active low; map all ones, count 37, identifier 0, kept prn
//   and index cleared, no result pending
`timescale 1ns / 1ps

module ble_csa2_channel_select_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csa2_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // [15:0] evt_count
    input  logic [1:0]                    s_tuser,  // [1:0] req_type
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata   // [5:0] channel, [11:6] used_index, zeros above
);

    // configuration registers
    logic [csa2_pkg::MAP_W-1:0]  r_channel_map;
    logic [csa2_pkg::CNT_W-1:0]  r_used_count;
    logic [csa2_pkg::ID_W-1:0]   r_chan_id;

    logic                        cfg_wr;
    logic [1:0]                  reg_idx;

    csa2_pkg::t_dp_cmd           cmd;
    csa2_pkg::t_dp_stat          stat;
    logic [csa2_pkg::CHAN_W-1:0] out_ch;
    logic [csa2_pkg::CHAN_W-1:0] out_remap;

    assign pready  = 1'b1;
    // registers sit on 8-byte steps since the map is wider than 32 bits
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_map <= '1;
            r_used_count  <= csa2_pkg::CNT_W'(37);
            r_chan_id     <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                csa2_pkg::REG_MAP:   r_channel_map <= pwdata[csa2_pkg::MAP_W-1:0];
                csa2_pkg::REG_COUNT: r_used_count  <= pwdata[csa2_pkg::CNT_W-1:0];
                csa2_pkg::REG_ID:    r_chan_id     <= pwdata[csa2_pkg::ID_W-1:0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (reg_idx)
            csa2_pkg::REG_MAP:   prdata = {{(64 - csa2_pkg::MAP_W){1'b0}}, r_channel_map};
            csa2_pkg::REG_COUNT: prdata = {{(64 - csa2_pkg::CNT_W){1'b0}}, r_used_count};
            csa2_pkg::REG_ID:    prdata = {{(64 - csa2_pkg::ID_W){1'b0}}, r_chan_id};
            default:             prdata = '0;
        endcase
    end

    // sequencer: accept, prn rounds, divide, scan, hand the beat over
    csa2_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath holds the kept iso state and the output register
    csa2_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (s_tuser),
        .i_evt_count     (s_tdata),
        .i_channel_map   (r_channel_map),
        .i_used_count    (r_used_count),
        .i_chan_id       (r_chan_id),
        .o_m_valid       (m_tvalid),
        .i_m_ready       (m_tready),
        .o_channel       (out_ch),
        .o_used_index    (out_remap)
    );

    // result beat packing
    assign m_tdata = {4'b0000, out_remap, out_ch};

endmodule
